### design/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    // Depth of the queue. It holds at most DEPTH - 1 entries.
    localparam int DEPTH = 64;
    localparam int CAP   = DEPTH - 1;
    localparam int CNT_W = $clog2(DEPTH);

    localparam int VALUE_W = 16;
    localparam int PRIO_W  = 8;
    localparam int OCC_W   = 6;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic               mode;
        logic [VALUE_W-1:0] item_value;
        logic [PRIO_W-1:0]  item_priority;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] out_value;
        t_status            status;
        logic [OCC_W-1:0]   occupancy;
    } t_out_item;

    // One stored entry of the chain.
    typedef struct packed {
        logic [VALUE_W-1:0] data;
        logic [PRIO_W-1:0]  prio;
    } t_entry;

    // Command broadcast to every cell in the cycle of a transaction.
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry item;
    } t_cell_cmd;

endpackage

### design/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  logic               i_occupied,
    input  logic               i_left_occupied,
    input  logic               i_left_greater,
    input  spq_pkg::t_entry    i_left_entry,
    input  spq_pkg::t_entry    i_right_entry,
    output spq_pkg::t_entry    o_entry,
    output logic               o_greater
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // This entry must make room for the new one when its priority is larger.
    assign o_greater = i_occupied && (r_entry.prio > i_cmd.item.prio);

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.enq) begin
            if (i_left_greater) begin
                n_entry = i_left_entry;
            end else if ((o_greater || !i_occupied) && i_left_occupied) begin
                n_entry = i_cmd.item;
            end
        end else if (i_cmd.deq) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

### design/sorted_insert_priority_queue.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  spq_pkg::t_in_item  (mode, value, priority)
// output    out        o_valid / i_stall  spq_pkg::t_out_item (value, status, occupancy)
//
// All cells compare their priority with the new one in parallel and shift in the
// same clock edge, so a new transaction can be taken in every cycle unless the
// input is stalled. The result is written to the output register on acceptance.
// Reset (synchronous, active low) empties the queue; the cell
// payload is not cleared, occupancy comes from the entry count alone. A stalled
// result holds the output register, and the input is stalled only while that
// register is full and stalled.

module sorted_insert_priority_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  spq_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output spq_pkg::t_out_item  o_item
);

    // Entry count; cells 0 .. r_count-1 hold live entries, head in cell 0.
    logic [spq_pkg::CNT_W-1:0] r_count;
    logic [spq_pkg::CNT_W-1:0] n_count;
    logic                      r_out_valid;
    logic                      n_out_valid;
    spq_pkg::t_out_item        r_out;
    spq_pkg::t_out_item        n_out;

    logic                      accept;
    logic                      is_full;
    logic                      is_empty;
    spq_pkg::t_cell_cmd        cmd;

    spq_pkg::t_entry           entry   [spq_pkg::CAP];
    logic [spq_pkg::CAP-1:0]   occupied;
    logic [spq_pkg::CAP-1:0]   greater;

    // The input is held off only while a finished result waits downstream.
    assign o_stall  = r_out_valid && i_stall;
    assign accept   = i_valid && !o_stall;
    assign is_full  = (r_count == spq_pkg::CNT_W'(spq_pkg::CAP));
    assign is_empty = (r_count == '0);

    // Refused operations leave the chain untouched.
    assign cmd.enq  = accept && (i_item.mode == spq_pkg::MODE_ENQ) && !is_full;
    assign cmd.deq  = accept && (i_item.mode == spq_pkg::MODE_DEQ) && !is_empty;
    assign cmd.item.data = i_item.item_value;
    assign cmd.item.prio = i_item.item_priority;

    // Row of compare-and-shift cells. On an enqueue every cell whose left
    // neighbor holds a larger priority takes that neighbor's entry. The new
    // entry lands in the first cell with a larger priority, or in the first
    // free cell when no live entry is larger.
    // On a dequeue every cell takes its right neighbor's entry.
    for (genvar g = 0; g < spq_pkg::CAP; g++) begin : g_cell
        logic            left_occupied;
        logic            left_greater;
        spq_pkg::t_entry left_entry;
        spq_pkg::t_entry right_entry;

        assign occupied[g] = (r_count > spq_pkg::CNT_W'(g));

        if (g == 0) begin : g_head
            assign left_occupied = 1'b1;
            assign left_greater  = 1'b0;
            assign left_entry    = cmd.item;
        end else begin : g_body
            assign left_occupied = occupied[g-1];
            assign left_greater  = greater[g-1];
            assign left_entry    = entry[g-1];
        end

        if (g == spq_pkg::CAP - 1) begin : g_tail
            assign right_entry = entry[g];
        end else begin : g_mid
            assign right_entry = entry[g+1];
        end

        spq_cell u_cell (
            .i_clk           (i_clk),
            .i_cmd           (cmd),
            .i_occupied      (occupied[g]),
            .i_left_occupied (left_occupied),
            .i_left_greater  (left_greater),
            .i_left_entry    (left_entry),
            .i_right_entry   (right_entry),
            .o_entry         (entry[g]),
            .o_greater       (greater[g])
        );
    end

    // Count and result for the transaction being accepted.
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        if (cmd.enq) begin
            n_count = r_count + 1'b1;
        end else if (cmd.deq) begin
            n_count = r_count - 1'b1;
        end
        if (accept) begin
            n_out_valid         = 1'b1;
            n_out.out_value     = cmd.deq ? entry[0].data : '0;
            n_out.occupancy     = spq_pkg::OCC_W'(n_count);
            if ((i_item.mode == spq_pkg::MODE_ENQ) && is_full) begin
                n_out.status = spq_pkg::ST_FULL;
            end else if ((i_item.mode == spq_pkg::MODE_DEQ) && is_empty) begin
                n_out.status = spq_pkg::ST_EMPTY;
            end else begin
                n_out.status = spq_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // The count never passes the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::CNT_W'(spq_pkg::CAP))
        else $error("entry count above capacity");

    // A successful enqueue adds exactly one entry.
    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.enq |=> r_count == $past(r_count) + 1'b1)
        else $error("enqueue did not add one entry");

    // A refused enqueue reports full and leaves the count alone.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.mode == spq_pkg::MODE_ENQ) && is_full
        |=> r_out_valid && (r_out.status == spq_pkg::ST_FULL) && $stable(r_count))
        else $error("full enqueue not refused");

    // The head never has a larger priority than the entry behind it.
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupied[1] |-> entry[0].prio <= entry[1].prio)
        else $error("head entry out of order");

endmodule
